[rtl/assert_macros.svh]
// Assertion macros shared by the alert table RTL.
// Each macro takes a label, the clock, the reset and the checked expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/adt_pkg.sv]
// Package for the alert table frame builder: request word type, queue status
// and frame constants. No dependencies.
`default_nettype none

package adt_pkg;

  localparam int NUM_SLOTS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [3:0] PRIO_MAX  = 4'd14;
  localparam logic [3:0] PRIO_TAG  = 4'hC;
  localparam logic [7:0] CLEAR_B0  = 8'h7F;
  localparam logic [7:0] CLEAR_B1  = 8'hFF;

  typedef struct packed {
    logic        present;
    logic [14:0] alert_id;
    logic [3:0]  prio;
    logic [7:0]  parameters;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

[rtl/adt_front.sv]
// Front end: takes request words, drops the reserved id and saturates priority.
// Depends on adt_pkg.
`default_nettype none

module adt_front (
  input  wire logic              start,
  input  wire adt_pkg::q_status_t qs,
  input  wire logic              present,
  input  wire logic [14:0]       alert_id,
  input  wire logic [7:0]        priority_req,
  input  wire logic [7:0]        parameters,
  output logic                   busy,
  output logic                   push,
  output adt_pkg::req_t          item
);
  import adt_pkg::*;

  always_comb begin
    busy            = qs.full;
    push            = start && !qs.full && (alert_id != 15'd0);
    item.present    = present;
    item.alert_id   = alert_id;
    item.prio       = (priority_req > {4'd0, PRIO_MAX}) ? PRIO_MAX : priority_req[3:0];
    item.parameters = parameters;
  end

endmodule

`default_nettype wire

[rtl/adt_queue.sv]
// Short request queue between the front end and the table engine.
// Depends on adt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module adt_queue #(
  parameter int DEPTH = adt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire adt_pkg::req_t      din,
  input  wire logic               pop,
  output adt_pkg::req_t           dout,
  output adt_pkg::q_status_t      qs
);
  import adt_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  req_t          mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  always_comb begin
    qs.full  = (count == CW'(DEPTH));
    qs.empty = (count == '0);
    do_push  = push && !qs.full;
    do_pop   = pop && !qs.empty;
    dout     = mem[rptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

  `ASSERT_ALWAYS(a_count_range, clk, rst, count <= CW'(DEPTH))
  `ASSERT_NEXT(a_push_counts, clk, rst, push && !pop && !qs.full, count == $past(count) + 1'b1)

endmodule

`default_nettype wire

[rtl/adt_back.sv]
// Table engine: scans the slot table one slot per cycle, updates it and
// builds the frame. Depends on adt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module adt_back #(
  parameter int NUM_SLOTS = adt_pkg::NUM_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire adt_pkg::q_status_t qs,
  input  wire adt_pkg::req_t      qdata,
  output logic                    pop,
  output logic                    done,
  output logic [7:0]              frame_byte0,
  output logic [7:0]              frame_byte1,
  output logic [7:0]              frame_byte2,
  output logic [7:0]              frame_byte3
);
  import adt_pkg::*;

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IW-1:0] LAST = IW'(NUM_SLOTS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_ACT  = 2'd2;

  logic [1:0]    state;
  logic [IW-1:0] idx;
  req_t          cur;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic [7:0]    hit_params;
  logic          free_ok;
  logic [IW-1:0] free_idx;
  logic [14:0]   slot_ids [NUM_SLOTS];
  logic [7:0]    slot_prm [NUM_SLOTS];
  logic [14:0]   rd_id;
  logic [7:0]    rd_prm;
  logic          do_clear;
  logic          do_show;

  always_comb begin
    pop      = (state == ST_IDLE) && !qs.empty;
    rd_id    = slot_ids[idx];
    rd_prm   = slot_prm[idx];
    do_clear = hit && !(cur.present && (hit_params == cur.parameters));
    do_show  = !hit && cur.present && free_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      idx     <= '0;
      hit     <= 1'b0;
      free_ok <= 1'b0;
      done    <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_ids[i] <= '0;
        slot_prm[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (pop) begin
            idx     <= '0;
            hit     <= 1'b0;
            free_ok <= 1'b0;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_id == cur.alert_id) begin
            hit   <= 1'b1;
            state <= ST_ACT;
          end else begin
            if ((rd_id == 15'd0) && !free_ok) begin
              free_ok <= 1'b1;
            end
            if (idx == LAST) begin
              state <= ST_ACT;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_ACT: begin
          if (do_clear) begin
            slot_ids[hit_idx] <= '0;
            slot_prm[hit_idx] <= '0;
          end else if (do_show) begin
            slot_ids[free_idx] <= cur.alert_id;
            slot_prm[free_idx] <= cur.parameters;
          end
          done  <= do_clear || do_show;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= qdata;
    end
    if ((state == ST_SCAN) && (rd_id == cur.alert_id)) begin
      hit_idx    <= idx;
      hit_params <= rd_prm;
    end
    if ((state == ST_SCAN) && (rd_id == 15'd0) && !free_ok) begin
      free_idx <= idx;
    end
    if (state == ST_ACT) begin
      frame_byte2 <= {PRIO_TAG, cur.prio};
      if (hit) begin
        frame_byte0 <= CLEAR_B0;
        frame_byte1 <= CLEAR_B1;
        frame_byte3 <= cur.present ? 8'd0 : cur.parameters;
      end else begin
        frame_byte0 <= {1'b1, cur.alert_id[14:8]};
        frame_byte1 <= cur.alert_id[7:0];
        frame_byte3 <= cur.parameters;
      end
    end
  end

  `ASSERT_IMPL(a_done_idle, clk, rst, done, state == ST_IDLE)
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done)

endmodule

`default_nettype wire

[rtl/alert_dedup_table_frame_builder_top.sv]
// Top level of the alert table frame builder: front end, request queue and
// table engine. Depends on adt_pkg, adt_front, adt_queue and adt_back.
//
//   Channel   Handshake               Fields
//   request   start, busy             present, alert_id, priority_req, parameters
//   frame     done (one-cycle strobe) frame_byte0 .. frame_byte3
//
// A request is written into the queue at the edge that takes it; the engine pops and
// loads it while idle, scans the table one slot per cycle until the id matches or the
// last slot is read, then updates the table and registers done and the frame bytes.
// It takes the next request only once it is back in its idle state.
// Busy rises only while the queue is full. Reset clears the table to empty.
// Frames cannot be held off, and done is shown for exactly one cycle.
`default_nettype none

module alert_dedup_table_frame_builder_top #(
  parameter int NUM_SLOTS   = adt_pkg::NUM_SLOTS_DEF,
  parameter int QUEUE_DEPTH = adt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        present,
  input  wire logic [14:0] alert_id,
  input  wire logic [7:0]  priority_req,
  input  wire logic [7:0]  parameters,
  output logic             done,
  output logic [7:0]       frame_byte0,
  output logic [7:0]       frame_byte1,
  output logic [7:0]       frame_byte2,
  output logic [7:0]       frame_byte3
);
  import adt_pkg::*;

  q_status_t qs;
  req_t      push_item;
  req_t      pop_item;
  logic      push;
  logic      pop;

  adt_front u_front (
    .start        (start),
    .qs           (qs),
    .present      (present),
    .alert_id     (alert_id),
    .priority_req (priority_req),
    .parameters   (parameters),
    .busy         (busy),
    .push         (push),
    .item         (push_item)
  );

  adt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (push_item),
    .pop  (pop),
    .dout (pop_item),
    .qs   (qs)
  );

  adt_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .qs          (qs),
    .qdata       (pop_item),
    .pop         (pop),
    .done        (done),
    .frame_byte0 (frame_byte0),
    .frame_byte1 (frame_byte1),
    .frame_byte2 (frame_byte2),
    .frame_byte3 (frame_byte3)
  );

endmodule

`default_nettype wire
